/* rtl/tdq_pkg.sv */
// shared widths, codes and compare helper for the timer deadline queue
package tdq_pkg;

   localparam int unsigned TDQ_CAPACITY = 16;
   localparam int unsigned MAX_RESULTS  = 16;

   localparam int unsigned ACT_W    = 2;
   localparam int unsigned ID_W     = 16;
   localparam int unsigned DL_W     = 32;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned KEY_W    = DL_W + ID_W;
   localparam int unsigned BURST_W  = $clog2(MAX_RESULTS + 1);

   localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_CANCEL = 2'd1;
   localparam logic [ACT_W-1:0] ACT_EXPIRE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MISSED    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NONE_DUE  = 3'd5;

   // (deadline, id) ordering, smaller id wins a tie
   function automatic logic key_less(input logic [DL_W-1:0] dl_a, input logic [ID_W-1:0] id_a,
                                     input logic [DL_W-1:0] dl_b, input logic [ID_W-1:0] id_b);
      return {dl_a, id_a} < {dl_b, id_b};
   endfunction

endpackage

/* rtl/tdq_ram.sv */
// generic single-write, single-read ram with registered read data
module tdq_ram #(
   parameter int unsigned WIDTH = tdq_pkg::KEY_W,
   parameter int unsigned DEPTH = tdq_pkg::TDQ_CAPACITY
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/timer_deadline_queue.sv */
// Timer deadline queue: keeps up to CAPACITY pending timers ordered by (deadline, id).
// Input channel req_*: one beat per action (add, cancel, expire up to req_now).
// Action code 3 is taken and dropped without any result.
// Result channel rsp_*: one beat for add and cancel; expire gives one beat per
// expired timer in deadline order (at most MAX_RESULTS), or a single "nothing
// expired" beat. rsp_last marks the final beat of an action.
// Every sweep of the slot ram reads one slot a cycle through a single key comparator,
// then ends in the done state, which loads the output register or starts another sweep.
// Add, cancel and a nothing-expired expire deliver their beat after one sweep. An
// expire that finds a due timer sweeps twice before its first beat, and each further
// beat follows one more sweep. The block takes one action at a time: req_stall stays
// high from acceptance until the last beat is loaded into the output register.
// rsp_stall holds the output register; a sweep that ends while a beat is held waits
// there until the beat is taken, so no beat is lost or repeated.
// Reset empties the table at once (slot valid flags in flops); the ram keeps
// whatever it held, and a sweep reads every slot but ignores one that is not valid.
module timer_deadline_queue #(
   parameter int unsigned CAPACITY = tdq_pkg::TDQ_CAPACITY
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tdq_pkg::ACT_W-1:0]      req_action,
   input  logic [tdq_pkg::ID_W-1:0]       req_timer_id,
   input  logic [tdq_pkg::DL_W-1:0]       req_deadline,
   input  logic [tdq_pkg::DL_W-1:0]       req_now,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tdq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [tdq_pkg::ID_W-1:0]       rsp_out_id,
   output logic [tdq_pkg::DL_W-1:0]       rsp_out_deadline,
   output logic                           rsp_earliest_changed,
   output logic [tdq_pkg::DL_W-1:0]       rsp_next_deadline,
   output logic                           rsp_next_valid,
   output logic                           rsp_last
);
   import tdq_pkg::*;

   localparam int unsigned IW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [ACT_W-1:0] act_ff, act_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic [DL_W-1:0] dl_ff, dl_in;
   logic [DL_W-1:0] now_ff, now_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;

   logic head_vld_ff, head_vld_in;
   logic [DL_W-1:0] head_dl_ff, head_dl_in;
   logic [ID_W-1:0] head_id_ff, head_id_in;
   logic [IW-1:0] head_idx_ff, head_idx_in;
   logic match_ff, match_in;
   logic [IW-1:0] match_idx_ff, match_idx_in;
   logic [DL_W-1:0] match_dl_ff, match_dl_in;
   logic free_ff, free_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;

   logic pend_ff, pend_in;
   logic [ID_W-1:0] prev_id_ff, prev_id_in;
   logic [DL_W-1:0] prev_dl_ff, prev_dl_in;
   logic [BURST_W-1:0] n_ff, n_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic [DL_W-1:0] rsp_dl_ff, rsp_dl_in;
   logic rsp_chg_ff, rsp_chg_in;
   logic [DL_W-1:0] rsp_nd_ff, rsp_nd_in;
   logic rsp_nv_ff, rsp_nv_in;
   logic rsp_last_ff, rsp_last_in;

   logic ram_we, ram_re;
   logic [KEY_W-1:0] ram_rd_data;
   logic [CW-1:0] cnt_m1;
   logic [IW-1:0] eval_idx;
   logic [DL_W-1:0] ev_dl;
   logic [ID_W-1:0] ev_id;
   logic ev_v, ev_match, ev_excl, ev_less;
   logic out_free, start_scan, earlier, due, burst_end;
   logic [DL_W-1:0] head_nd;

   assign ram_re   = (state_ff == ST_SCAN) && (cnt_ff < CW'(CAPACITY));
   assign cnt_m1   = cnt_ff - CW'(1);
   assign eval_idx = cnt_m1[IW-1:0];
   assign ev_dl    = ram_rd_data[KEY_W-1:ID_W];
   assign ev_id    = ram_rd_data[ID_W-1:0];
   assign ev_v     = valid_ff[eval_idx];
   assign ev_match = ev_v && (ev_id == id_ff);
   // a cancelled slot must not count as the next head
   assign ev_excl  = ev_match && (act_ff == ACT_CANCEL);
   assign ev_less  = key_less(ev_dl, ev_id, head_dl_ff, head_id_ff);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign head_nd   = head_vld_ff ? head_dl_ff : '0;
   assign earlier   = !head_vld_ff || (dl_ff < head_dl_ff);
   assign due       = head_vld_ff && (head_dl_ff <= now_ff);
   assign burst_end = (n_ff == BURST_W'(MAX_RESULTS)) || !due;

   tdq_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (free_idx_ff),
      .wr_data ({dl_ff, id_ff}),
      .rd_en   (ram_re),
      .rd_addr (cnt_ff[IW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      act_in       = act_ff;
      id_in        = id_ff;
      dl_in        = dl_ff;
      now_in       = now_ff;
      valid_in     = valid_ff;
      head_vld_in  = head_vld_ff;
      head_dl_in   = head_dl_ff;
      head_id_in   = head_id_ff;
      head_idx_in  = head_idx_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      match_dl_in  = match_dl_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      pend_in      = pend_ff;
      prev_id_in   = prev_id_ff;
      prev_dl_in   = prev_dl_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_dl_in    = rsp_dl_ff;
      rsp_chg_in   = rsp_chg_ff;
      rsp_nd_in    = rsp_nd_ff;
      rsp_nv_in    = rsp_nv_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      start_scan   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in = req_action;
               id_in  = req_timer_id;
               dl_in  = req_deadline;
               now_in = req_now;
               pend_in = 1'b0;
               n_in    = '0;
               if (req_action == ACT_ADD || req_action == ACT_CANCEL ||
                   req_action == ACT_EXPIRE) begin
                  start_scan = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // read data is registered, so it answers the address of the cycle before
            if (cnt_ff != '0) begin
               if (ev_match) begin
                  match_in     = 1'b1;
                  match_idx_in = eval_idx;
                  match_dl_in  = ev_dl;
               end
               if (!ev_v && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = eval_idx;
               end
               if (ev_v && !ev_excl && (!head_vld_ff || ev_less)) begin
                  head_vld_in = 1'b1;
                  head_dl_in  = ev_dl;
                  head_id_in  = ev_id;
                  head_idx_in = eval_idx;
               end
            end
            if (cnt_ff == CW'(CAPACITY)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_DONE: begin
            unique case (act_ff)
               ACT_ADD: begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_id_in    = id_ff;
                     rsp_dl_in    = dl_ff;
                     state_in     = ST_IDLE;
                     if (!free_ff || match_ff) begin
                        rsp_status_in = ST_REJECTED;
                        rsp_chg_in    = 1'b0;
                        rsp_nd_in     = head_nd;
                        rsp_nv_in     = head_vld_ff;
                     end else begin
                        ram_we                = 1'b1;
                        valid_in[free_idx_ff] = 1'b1;
                        rsp_status_in         = ST_ADDED;
                        rsp_chg_in            = earlier;
                        rsp_nd_in             = earlier ? dl_ff : head_dl_ff;
                        rsp_nv_in             = 1'b1;
                     end
                  end
               end
               ACT_CANCEL: begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_id_in    = id_ff;
                     rsp_chg_in   = 1'b0;
                     rsp_nd_in    = head_nd;
                     rsp_nv_in    = head_vld_ff;
                     state_in     = ST_IDLE;
                     if (match_ff) begin
                        valid_in[match_idx_ff] = 1'b0;
                        rsp_status_in          = ST_CANCELLED;
                        rsp_dl_in              = match_dl_ff;
                     end else begin
                        rsp_status_in = ST_MISSED;
                        rsp_dl_in     = '0;
                     end
                  end
               end
               ACT_EXPIRE: begin
                  if (!pend_ff) begin
                     if (due) begin
                        // first due timer: pull it and sweep again for its successor
                        valid_in[head_idx_ff] = 1'b0;
                        prev_id_in = head_id_ff;
                        prev_dl_in = head_dl_ff;
                        pend_in    = 1'b1;
                        n_in       = BURST_W'(1);
                        start_scan = 1'b1;
                     end else if (out_free) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NONE_DUE;
                        rsp_id_in     = '0;
                        rsp_dl_in     = '0;
                        rsp_chg_in    = 1'b0;
                        rsp_nd_in     = head_nd;
                        rsp_nv_in     = head_vld_ff;
                        rsp_last_in   = 1'b1;
                        state_in      = ST_IDLE;
                     end
                  end else if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_EXPIRED;
                     rsp_id_in     = prev_id_ff;
                     rsp_dl_in     = prev_dl_ff;
                     rsp_chg_in    = 1'b0;
                     rsp_nd_in     = head_nd;
                     rsp_nv_in     = head_vld_ff;
                     rsp_last_in   = burst_end;
                     if (burst_end) begin
                        pend_in  = 1'b0;
                        state_in = ST_IDLE;
                     end else begin
                        valid_in[head_idx_ff] = 1'b0;
                        prev_id_in = head_id_ff;
                        prev_dl_in = head_dl_ff;
                        n_in       = n_ff + BURST_W'(1);
                        start_scan = 1'b1;
                     end
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (start_scan) begin
         state_in    = ST_SCAN;
         cnt_in      = '0;
         head_vld_in = 1'b0;
         match_in    = 1'b0;
         free_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff        <= cnt_in;
      act_ff        <= act_in;
      id_ff         <= id_in;
      dl_ff         <= dl_in;
      now_ff        <= now_in;
      head_vld_ff   <= head_vld_in;
      head_dl_ff    <= head_dl_in;
      head_id_ff    <= head_id_in;
      head_idx_ff   <= head_idx_in;
      match_ff      <= match_in;
      match_idx_ff  <= match_idx_in;
      match_dl_ff   <= match_dl_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      prev_id_ff    <= prev_id_in;
      prev_dl_ff    <= prev_dl_in;
      n_ff          <= n_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_dl_ff     <= rsp_dl_in;
      rsp_chg_ff    <= rsp_chg_in;
      rsp_nd_ff     <= rsp_nd_in;
      rsp_nv_ff     <= rsp_nv_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_out_id           = rsp_id_ff;
   assign rsp_out_deadline     = rsp_dl_ff;
   assign rsp_earliest_changed = rsp_chg_ff;
   assign rsp_next_deadline    = rsp_nd_ff;
   assign rsp_next_valid       = rsp_nv_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

/* rtl/tdq_chk.sv */
// port-level checks for the timer deadline queue, bound to the top level
module tdq_chk #(
   parameter int unsigned CAPACITY = tdq_pkg::TDQ_CAPACITY
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [tdq_pkg::ACT_W-1:0]      req_action,
   input logic [tdq_pkg::ID_W-1:0]       req_timer_id,
   input logic [tdq_pkg::DL_W-1:0]       req_deadline,
   input logic [tdq_pkg::DL_W-1:0]       req_now,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [tdq_pkg::STATUS_W-1:0]   rsp_status,
   input logic [tdq_pkg::ID_W-1:0]       rsp_out_id,
   input logic [tdq_pkg::DL_W-1:0]       rsp_out_deadline,
   input logic                           rsp_earliest_changed,
   input logic [tdq_pkg::DL_W-1:0]       rsp_next_deadline,
   input logic                           rsp_next_valid,
   input logic                           rsp_last
);
   import tdq_pkg::*;

   localparam int unsigned CAP_CHECK = CAPACITY;

   // a held beat keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_out_id) &&
         $stable(rsp_out_deadline) && $stable(rsp_next_deadline) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // once a real action is taken, the input is closed
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_action == ACT_ADD || req_action == ACT_CANCEL ||
         req_action == ACT_EXPIRE) |=> req_stall)
      else $error("input reopened right after an action was taken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_next_valid |-> rsp_next_deadline == '0)
      else $error("next deadline not zero with empty table");

   // only an accepted add may move the earliest deadline, and it leaves a timer pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_earliest_changed |-> rsp_status == ST_ADDED && rsp_next_valid &&
         rsp_next_deadline == rsp_out_deadline && CAP_CHECK >= 2)
      else $error("earliest change flagged on a non-add beat");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NONE_DUE |-> rsp_last && rsp_out_id == '0 &&
         rsp_out_deadline == '0)
      else $error("nothing-expired beat malformed");

endmodule

bind timer_deadline_queue tdq_chk #(.CAPACITY(CAPACITY)) u_tdq_chk (.*);
